// File: hdl/unique_random_sequence_core_defines.svh
// Assertion macros for the unique random sequence core.
`ifndef UNIQUE_RANDOM_SEQUENCE_CORE_DEFINES_SVH
`define UNIQUE_RANDOM_SEQUENCE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define URS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unique_random_sequence_core: check failed");
`define URS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unique_random_sequence_core: check failed");
`else
`define URS_ASSERT_NOW(label, ante, cons)
`define URS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/urs_pkg.sv
// Package: constants, command types and state encoding of the sequence core.
`default_nettype none

package urs_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned FOLD_W    = DATA_W + 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [DATA_W-1:0] QR_PRIME      = 32'd4294967291;
    localparam logic [DATA_W-1:0] QR_HALF       = 32'd2147483645;
    localparam logic [DATA_W-1:0] SEED_IDX_SALT = 32'h682f0161;
    localparam logic [DATA_W-1:0] SEED_OFS_SALT = 32'h46790905;
    localparam logic [DATA_W-1:0] DRAW_XOR_MASK = 32'h5bf03635;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_INDEX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_OFFSET = 1'b1;

    typedef enum logic [2:0] {
        SRC_SEED_IDX,
        SRC_IDX_SALT,
        SRC_SEED_OFS,
        SRC_OFS_SALT,
        SRC_SEQ,
        SRC_MIX
    } src_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic     mul_en;
        logic     fold_en;
        logic     fin_en;
        src_sel_t src;
    } urs_cmd_t;

endpackage

`default_nettype wire

// File: hdl/urs_draw_if.sv
// Draw request channel: valid, ready and the restart flag.
`default_nettype none

interface urs_draw_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

// File: hdl/urs_result_if.sv
// Result channel: valid, ready and the drawn value.
`default_nettype none

interface urs_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/urs_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
`default_nettype none

interface urs_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/urs_ctrl.sv
// Controller: sequences the permutation operations of a restart and a draw.
`default_nettype none

module urs_ctrl
    import urs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     draw_valid,
    input  wire logic     draw_restart,
    output logic          draw_ready,
    output logic          result_valid,
    input  wire logic     result_ready,
    output urs_cmd_t      cmd
);

    state_t   state_reg, state_next;
    src_sel_t op_reg, op_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= SRC_SEQ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !result_ready;
        draw_ready     = 1'b0;
        cmd.mul_en     = 1'b0;
        cmd.fold_en    = 1'b0;
        cmd.fin_en     = 1'b0;
        cmd.src        = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                draw_ready = 1'b1;
                if (draw_valid)
                begin
                    op_next    = draw_restart ? SRC_SEED_IDX : SRC_SEQ;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold_en = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (op_reg == SRC_MIX)
                begin
                    if (out_free)
                    begin
                        cmd.fin_en     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.fin_en = 1'b1;
                    state_next = ST_MUL;
                    unique case (op_reg)
                        SRC_SEED_IDX: op_next = SRC_IDX_SALT;
                        SRC_IDX_SALT: op_next = SRC_SEED_OFS;
                        SRC_SEED_OFS: op_next = SRC_OFS_SALT;
                        SRC_OFS_SALT: op_next = SRC_SEQ;
                        SRC_SEQ:      op_next = SRC_MIX;
                        default:      op_next = SRC_MIX;
                    endcase
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/urs_datapath.sv
// Datapath: seed and state registers, shared squaring and modular reduction.
`default_nettype none

module urs_datapath
    import urs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire urs_cmd_t             cmd,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    output logic [DATA_W-1:0]         value
);

    logic [DATA_W-1:0] seed_index_reg;
    logic [DATA_W-1:0] seed_offset_reg;
    logic [DATA_W-1:0] seq_index_reg;
    logic [DATA_W-1:0] offset_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] x_next;
    logic [PROD_W-1:0] prod_reg;
    logic [FOLD_W-1:0] fold_reg;
    logic [FOLD_W-1:0] fold_next;
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W:0]   fold2;
    logic [DATA_W-1:0] residue;
    logic [DATA_W-1:0] perm_out;

    // operand select
    always_comb
    begin
        unique case (cmd.src)
            SRC_SEED_IDX: x_next = seed_index_reg;
            SRC_IDX_SALT: x_next = res_reg + SEED_IDX_SALT;
            SRC_SEED_OFS: x_next = seed_offset_reg;
            SRC_OFS_SALT: x_next = res_reg + SEED_OFS_SALT;
            SRC_SEQ:      x_next = seq_index_reg;
            SRC_MIX:      x_next = (res_reg + offset_reg) ^ DRAW_XOR_MASK;
            default:      x_next = seq_index_reg;
        endcase
    end

    // 2^32 = 5 mod p: fold the high word twice, then one conditional subtract
    assign fold_next = {1'b0, prod_reg[PROD_W-1:DATA_W], 2'b00}
                     + {3'b000, prod_reg[PROD_W-1:DATA_W]}
                     + {3'b000, prod_reg[DATA_W-1:0]};
    assign fold2     = {1'b0, fold_reg[DATA_W-1:0]}
                     + {{(DATA_W-4){1'b0}}, fold_reg[FOLD_W-1:DATA_W], 2'b00}
                     + {{(DATA_W-2){1'b0}}, fold_reg[FOLD_W-1:DATA_W]};
    assign residue   = (fold2 >= {1'b0, QR_PRIME}) ? fold2[DATA_W-1:0] - QR_PRIME
                                                   : fold2[DATA_W-1:0];

    always_comb
    begin
        priority if (x_reg >= QR_PRIME)
            perm_out = x_reg;
        else if (x_reg <= QR_HALF)
            perm_out = residue;
        else
            perm_out = QR_PRIME - residue;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            x_reg    <= x_next;
            prod_reg <= PROD_W'(x_next) * PROD_W'(x_next);
        end
        if (cmd.fold_en)
            fold_reg <= fold_next;
        if (cmd.fin_en)
            res_reg <= perm_out;
        if (cmd.fin_en && cmd.src == SRC_MIX)
            value_reg <= perm_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_index_reg  <= '0;
            seed_offset_reg <= '0;
            seq_index_reg   <= '0;
            offset_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SEED_INDEX:  seed_index_reg  <= cfg_data;
                    CFG_SEED_OFFSET: seed_offset_reg <= cfg_data;
                endcase
            end
            if (cmd.mul_en && cmd.src == SRC_SEQ)
                seq_index_reg <= seq_index_reg + DATA_W'(1);
            else if (cmd.fin_en && cmd.src == SRC_IDX_SALT)
                seq_index_reg <= perm_out;
            if (cmd.fin_en && cmd.src == SRC_OFS_SALT)
                offset_reg <= perm_out;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: hdl/unique_random_sequence_core.sv
// Top level of the unique random sequence core.
`default_nettype none
`include "unique_random_sequence_core_defines.svh"

// Draws a non-repeating 32-bit sequence from the quadratic residue permutation
// over p = 2^32 - 5. One shared three-stage unit (32x32 square, first fold,
// second fold with final subtract and mirror) evaluates each permutation.
// A draw needs two permutations before the next request is accepted; a
// restart request adds four permutations. The request channel is ready
// whenever the unit is idle, also while a result waits; the next result is
// held in the unit until the waiting one is taken. Seed writes take effect
// at the next restart.
module unique_random_sequence_core
    import urs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    urs_draw_if.sink      draw,
    urs_result_if.source  result,
    urs_cfg_if.sink       cfg
);

    urs_cmd_t cmd;

    assign cfg.ready = 1'b1;

    urs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .draw_valid   (draw.valid),
        .draw_restart (draw.restart),
        .draw_ready   (draw.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    urs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .value     (result.value)
    );

    `URS_ASSERT_NEXT(a_busy_after_transfer, draw.valid && draw.ready, !draw.ready)
    `URS_ASSERT_NOW(a_one_stage, 1'b1, $onehot0({cmd.mul_en, cmd.fold_en, cmd.fin_en}))
    `URS_ASSERT_NOW(a_no_overwrite, cmd.fin_en && cmd.src == SRC_MIX, !result.valid || result.ready)
    `URS_ASSERT_NEXT(a_result_after_finish, cmd.fin_en && cmd.src == SRC_MIX, result.valid)

endmodule

`default_nettype wire
